// ===== src/imt_pkg.sv =====
// ----------------------------------------------------------------------------
// imt_pkg: shared types and constants of the IRC message tokenizer
// Holds the parse phases, record kinds, record layout and queue sizing.
// ----------------------------------------------------------------------------
package imt_pkg;

    // Largest number of parameters whose index is told apart.
    localparam int MAX_PARAMS = 16;

    // Highest parameter index that the 4-bit index field reports.
    localparam logic [3:0] PARAM_CAP =
        (MAX_PARAMS - 1 > 15) ? 4'd15 : 4'(MAX_PARAMS - 1);

    // Result queue depth; a power of two so that the pointers wrap freely.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Special characters of the stream.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        PH_MSG    = 3'd0,
        PH_PREFIX = 3'd1,
        PH_COMMAND = 3'd2,
        PH_PFIRST = 3'd3,
        PH_PARAM  = 3'd4,
        PH_TRAIL  = 3'd5,
        PH_PNEXT  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        K_PREFIX  = 3'd0,
        K_COMMAND = 3'd1,
        K_PARAM   = 3'd2,
        K_TRAIL   = 3'd3,
        K_END     = 3'd4
    } kind_t;

    // Parser state carried from byte to byte.
    typedef struct packed {
        phase_t     phase;
        logic       has_bytes;
        logic [3:0] pcount;
        logic       ovf;
    } parse_state_t;

    // One result record.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       start;
        logic       empty;
        logic [3:0] pidx;
        logic       povf;
        logic       last;
    } rec_t;

    // Outcome of handling one character: new state and an optional record.
    typedef struct packed {
        parse_state_t st;
        logic         rec_valid;
        rec_t         rec;
    } step_t;

endpackage

// ===== src/irc_message_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// irc_message_tokenizer_core: byte-wise IRC message tokenizer
// Tags each received byte as prefix, command, parameter or trailing text and
// closes each CR LF terminated message with an end record.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_stall  | data_byte
//  output  | out_valid / out_stall| kind, out_byte, token_start, empty_token,
//          |                      | param_index, param_overflow, last
//
// A byte is parsed in the cycle it is accepted; its zero, one or two records
// enter a four-entry result queue and leave it one per cycle while out_stall is low.
// One byte per cycle is sustained while out_stall is low and bytes give one
// record each; a byte that gives two records leaves one more in the queue.
// in_stall rises when fewer than two queue entries are free.
// Reset clears the parser state and empties the queue; no clearing pass.
module irc_message_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] out_byte,
    output logic       token_start,
    output logic       empty_token,
    output logic [3:0] param_index,
    output logic       param_overflow,
    output logic       last
);
    import imt_pkg::*;

    // Build a record; parameter fields are shown on parameter records only.
    function automatic rec_t make_rec(input kind_t k, input logic [7:0] b,
                                      input logic st, input logic em,
                                      input parse_state_t s);
        rec_t r;
        r.kind  = k;
        r.data  = b;
        r.start = st;
        r.empty = em;
        r.pidx  = (k == K_PARAM) ? s.pcount : 4'd0;
        r.povf  = (k == K_PARAM) ? s.ovf : 1'b0;
        r.last  = 1'b0;
        return r;
    endfunction

    // Handle one content character in the current phase.
    function automatic step_t content_step(input parse_state_t s,
                                           input logic [7:0] b);
        step_t r;
        kind_t k;
        r.st        = s;
        r.rec_valid = 1'b0;
        r.rec       = '0;
        k           = (s.phase == PH_PREFIX) ? K_PREFIX : K_COMMAND;
        unique case (s.phase)
            PH_MSG:
            begin
                if (b == CH_COLON)
                begin
                    r.st.phase     = PH_PREFIX;
                    r.st.has_bytes = 1'b0;
                end
                else if (b == CH_SPACE)
                begin
                    r.rec_valid = 1'b1;
                    r.rec       = make_rec(K_COMMAND, 8'd0, 1'b1, 1'b1, r.st);
                    r.st.phase  = PH_PFIRST;
                end
                else
                begin
                    r.rec_valid    = 1'b1;
                    r.rec          = make_rec(K_COMMAND, b, 1'b1, 1'b0, r.st);
                    r.st.phase     = PH_COMMAND;
                    r.st.has_bytes = 1'b1;
                end
            end
            PH_PREFIX, PH_COMMAND:
            begin
                if (b == CH_SPACE)
                begin
                    if (!s.has_bytes)
                    begin
                        r.rec_valid = 1'b1;
                        r.rec       = make_rec(k, 8'd0, 1'b1, 1'b1, r.st);
                    end
                    r.st.phase     = (s.phase == PH_PREFIX) ? PH_COMMAND : PH_PFIRST;
                    r.st.has_bytes = 1'b0;
                end
                else
                begin
                    r.rec_valid    = 1'b1;
                    r.rec          = make_rec(k, b, !s.has_bytes, 1'b0, r.st);
                    r.st.has_bytes = 1'b1;
                end
            end
            PH_PFIRST, PH_PNEXT:
            begin
                if (b == CH_COLON)
                begin
                    r.st.phase     = PH_TRAIL;
                    r.st.has_bytes = 1'b0;
                end
                else
                begin
                    // Moving on to a further parameter bumps the index.
                    if (s.phase == PH_PNEXT)
                    begin
                        if (s.pcount < PARAM_CAP)
                            r.st.pcount = s.pcount + 4'd1;
                        else
                            r.st.ovf = 1'b1;
                    end
                    r.rec_valid = 1'b1;
                    if (b == CH_SPACE)
                    begin
                        r.rec      = make_rec(K_PARAM, 8'd0, 1'b1, 1'b1, r.st);
                        r.st.phase = PH_PNEXT;
                    end
                    else
                    begin
                        r.rec          = make_rec(K_PARAM, b, 1'b1, 1'b0, r.st);
                        r.st.phase     = PH_PARAM;
                        r.st.has_bytes = 1'b1;
                    end
                end
            end
            PH_PARAM:
            begin
                if (b == CH_SPACE)
                begin
                    r.st.phase     = PH_PNEXT;
                    r.st.has_bytes = 1'b0;
                end
                else
                begin
                    r.rec_valid = 1'b1;
                    r.rec       = make_rec(K_PARAM, b, 1'b0, 1'b0, r.st);
                end
            end
            default:
            begin
                // Trailing text, and the unused phase code, take every byte.
                r.st.phase     = PH_TRAIL;
                r.rec_valid    = 1'b1;
                r.rec          = make_rec(K_TRAIL, b, !s.has_bytes, 1'b0, r.st);
                r.st.has_bytes = 1'b1;
            end
        endcase
        return r;
    endfunction

    parse_state_t st_reg, st_next;
    logic         cr_held_reg, cr_held_next;

    rec_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    logic  in_acc, out_acc;
    step_t step_a, step_b;
    rec_t  rec_a, rec_b, push0, push1;
    logic  va, vb;
    logic  [1:0] push_cnt;
    parse_state_t cleared;

    assign in_stall  = (count_reg > FIFO_CW'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    // Parse the accepted byte, with a held CR handled first.
    always_comb
    begin
        cleared.phase     = PH_MSG;
        cleared.has_bytes = 1'b0;
        cleared.pcount    = 4'd0;
        cleared.ovf       = 1'b0;
        step_a            = '0;
        step_b            = '0;
        rec_a             = '0;
        rec_b             = '0;
        va                = 1'b0;
        vb                = 1'b0;
        st_next           = st_reg;
        cr_held_next      = cr_held_reg;
        if (in_acc)
        begin
            if (cr_held_reg && data_byte == CH_LF)
            begin
                // End of message: close an open token with no bytes.
                cr_held_next = 1'b0;
                if (st_reg.phase == PH_MSG ||
                    (st_reg.phase == PH_COMMAND && !st_reg.has_bytes))
                begin
                    va    = 1'b1;
                    rec_a = make_rec(K_COMMAND, 8'd0, 1'b1, 1'b1, st_reg);
                end
                else if (st_reg.phase == PH_PREFIX && !st_reg.has_bytes)
                begin
                    va    = 1'b1;
                    rec_a = make_rec(K_PREFIX, 8'd0, 1'b1, 1'b1, st_reg);
                end
                else if (st_reg.phase == PH_TRAIL && !st_reg.has_bytes)
                begin
                    va    = 1'b1;
                    rec_a = make_rec(K_TRAIL, 8'd0, 1'b1, 1'b1, st_reg);
                end
                vb      = 1'b1;
                rec_b   = make_rec(K_END, 8'd0, 1'b0, 1'b0, st_reg);
                st_next = cleared;
            end
            else
            begin
                // A held CR that is not followed by LF counts as content.
                if (cr_held_reg)
                    step_a = content_step(st_reg, CH_CR);
                else
                begin
                    step_a.st        = st_reg;
                    step_a.rec_valid = 1'b0;
                end
                if (data_byte == CH_CR)
                begin
                    cr_held_next     = 1'b1;
                    step_b.st        = step_a.st;
                    step_b.rec_valid = 1'b0;
                end
                else
                begin
                    cr_held_next = 1'b0;
                    step_b       = content_step(step_a.st, data_byte);
                end
                va      = step_a.rec_valid;
                rec_a   = step_a.rec;
                vb      = step_b.rec_valid;
                rec_b   = step_b.rec;
                st_next = step_b.st;
            end
        end
    end

    // Pack the records in order and mark the final one of this byte.
    always_comb
    begin
        push0      = va ? rec_a : rec_b;
        push0.last = !(va && vb);
        push1      = rec_b;
        push1.last = 1'b1;
        push_cnt   = {1'b0, va} + {1'b0, vb};
        count_next = count_reg + FIFO_CW'(push_cnt) - FIFO_CW'(out_acc);
    end

    // Parser state and queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase     <= PH_MSG;
            st_reg.has_bytes <= 1'b0;
            st_reg.pcount    <= 4'd0;
            st_reg.ovf       <= 1'b0;
            cr_held_reg      <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            st_reg      <= st_next;
            cr_held_reg <= cr_held_next;
            wr_ptr_reg  <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg  <= rd_ptr_reg + FIFO_AW'(out_acc);
            count_reg   <= count_next;
        end
    end

    // Queue storage; only free entries are written.
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= push1;
    end

    // Head of the queue drives the output beat.
    assign kind           = fifo_reg[rd_ptr_reg].kind;
    assign out_byte       = fifo_reg[rd_ptr_reg].data;
    assign token_start    = fifo_reg[rd_ptr_reg].start;
    assign empty_token    = fifo_reg[rd_ptr_reg].empty;
    assign param_index    = fifo_reg[rd_ptr_reg].pidx;
    assign param_overflow = fifo_reg[rd_ptr_reg].povf;
    assign last           = fifo_reg[rd_ptr_reg].last;

    // The queue never holds more entries than it has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // A fresh CR is held back and gives no record.
    a_cr_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !cr_held_reg && data_byte == CH_CR) |-> (push_cnt == 2'd0)
            ##1 cr_held_reg)
        else $error("lone CR not held");

    // An end record always closes the records of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_END) |-> (last && !token_start && !empty_token))
        else $error("end record malformed");

    // Parameter fields stay clear outside parameter records.
    a_param_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != K_PARAM) |-> (param_index == 4'd0 && !param_overflow))
        else $error("parameter fields on non-parameter record");

    // The parameter index saturates at its cap and clears at message end.
    a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.pcount <= PARAM_CAP) && (st_reg.phase != PH_MSG || st_reg.pcount == 4'd0))
        else $error("parameter index out of range");

endmodule

// ===== tb/irc_message_tokenizer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irc_message_tokenizer_checker: record predictor and scoreboard
// Watches the byte and record channels of the tokenizer, works out the
// records that every accepted byte must cause and compares each record that
// leaves the block against the oldest one still waiting.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] kind,
    input  logic [7:0] out_byte,
    input  logic       token_start,
    input  logic       empty_token,
    input  logic [3:0] param_index,
    input  logic       param_overflow,
    input  logic       last,
    output int         fail_count,
    output int         pending_count
);
    import imt_pkg::*;

    // Parser state of the predictor.
    phase_t     tok_phase;
    logic       cr_held;
    logic       token_open;
    logic [3:0] param_num;
    logic       param_ovf;

    // Records still owed by the block, oldest first.
    rec_t expected_records[$];

    // The newest record of the current beat is held back until it is known
    // whether it is the last one.
    rec_t newest_rec;
    logic newest_valid;

    rec_t want;
    int   fail_total;

    assign fail_count = fail_total;

    task automatic add_record(input kind_t k, input logic [7:0] b, input logic st,
                              input logic em, input logic is_param);
        if (newest_valid)
            expected_records = {expected_records, newest_rec};
        newest_rec.kind  = k;
        newest_rec.data  = b;
        newest_rec.start = st;
        newest_rec.empty = em;
        newest_rec.pidx  = is_param ? param_num : 4'd0;
        newest_rec.povf  = is_param ? param_ovf : 1'b0;
        newest_rec.last  = 1'b0;
        newest_valid = 1'b1;
    endtask

    // Tag one content byte according to the current parse phase.
    task automatic tag_content(input logic [7:0] b);
        kind_t tok_kind;
        case (tok_phase)
            PH_MSG:
            begin
                if (b == CH_COLON)
                begin
                    tok_phase  = PH_PREFIX;
                    token_open = 1'b0;
                end
                else if (b == CH_SPACE)
                begin
                    add_record(K_COMMAND, 8'd0, 1'b1, 1'b1, 1'b0);
                    tok_phase = PH_PFIRST;
                end
                else
                begin
                    add_record(K_COMMAND, b, 1'b1, 1'b0, 1'b0);
                    tok_phase  = PH_COMMAND;
                    token_open = 1'b1;
                end
            end
            PH_PREFIX, PH_COMMAND:
            begin
                tok_kind = (tok_phase == PH_PREFIX) ? K_PREFIX : K_COMMAND;
                if (b == CH_SPACE)
                begin
                    if (!token_open)
                        add_record(tok_kind, 8'd0, 1'b1, 1'b1, 1'b0);
                    tok_phase  = (tok_phase == PH_PREFIX) ? PH_COMMAND : PH_PFIRST;
                    token_open = 1'b0;
                end
                else
                begin
                    add_record(tok_kind, b, !token_open, 1'b0, 1'b0);
                    token_open = 1'b1;
                end
            end
            PH_PFIRST, PH_PNEXT:
            begin
                if (b == CH_COLON)
                begin
                    tok_phase  = PH_TRAIL;
                    token_open = 1'b0;
                end
                else
                begin
                    // A new parameter starts; the index saturates at the cap.
                    if (tok_phase == PH_PNEXT)
                    begin
                        if (param_num < PARAM_CAP)
                            param_num = param_num + 4'd1;
                        else
                            param_ovf = 1'b1;
                    end
                    if (b == CH_SPACE)
                    begin
                        add_record(K_PARAM, 8'd0, 1'b1, 1'b1, 1'b1);
                        tok_phase = PH_PNEXT;
                    end
                    else
                    begin
                        add_record(K_PARAM, b, 1'b1, 1'b0, 1'b1);
                        tok_phase  = PH_PARAM;
                        token_open = 1'b1;
                    end
                end
            end
            PH_PARAM:
            begin
                if (b == CH_SPACE)
                begin
                    tok_phase  = PH_PNEXT;
                    token_open = 1'b0;
                end
                else
                begin
                    add_record(K_PARAM, b, 1'b0, 1'b0, 1'b1);
                end
            end
            default:
            begin
                tok_phase = PH_TRAIL;
                add_record(K_TRAIL, b, !token_open, 1'b0, 1'b0);
                token_open = 1'b1;
            end
        endcase
    endtask

    // Work out every record caused by one accepted byte.
    task automatic predict_byte(input logic [7:0] b);
        logic msg_done;
        msg_done     = 1'b0;
        newest_valid = 1'b0;
        if (cr_held)
        begin
            cr_held = 1'b0;
            if (b == CH_LF)
            begin
                // Close the message, reporting a token left open with no bytes.
                if (tok_phase == PH_MSG || (tok_phase == PH_COMMAND && !token_open))
                    add_record(K_COMMAND, 8'd0, 1'b1, 1'b1, 1'b0);
                else if (tok_phase == PH_PREFIX && !token_open)
                    add_record(K_PREFIX, 8'd0, 1'b1, 1'b1, 1'b0);
                else if (tok_phase == PH_TRAIL && !token_open)
                    add_record(K_TRAIL, 8'd0, 1'b1, 1'b1, 1'b0);
                add_record(K_END, 8'd0, 1'b0, 1'b0, 1'b0);
                tok_phase  = PH_MSG;
                token_open = 1'b0;
                param_num  = 4'd0;
                param_ovf  = 1'b0;
                msg_done   = 1'b1;
            end
            else
            begin
                // A lone CR turns into content ahead of the new byte.
                tag_content(CH_CR);
            end
        end
        if (!msg_done)
        begin
            if (b == CH_CR)
                cr_held = 1'b1;
            else
                tag_content(b);
        end
        if (newest_valid)
        begin
            newest_rec.last  = 1'b1;
            expected_records = {expected_records, newest_rec};
        end
    endtask

    task automatic check_field(input string fname, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h",
                     $time, fname, exp_val, act_val);
            fail_total++;
        end
    endtask

    // Outputs leave the block in the cycle after their byte at the earliest, so the
    // compare may run ahead of the prediction at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_phase     = PH_MSG;
            cr_held       = 1'b0;
            token_open    = 1'b0;
            param_num     = 4'd0;
            param_ovf     = 1'b0;
            newest_valid  = 1'b0;
            fail_total    = 0;
            expected_records.delete();
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t ns: unexpected record, kind %0d byte %0h",
                             $time, kind, out_byte);
                    fail_total++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("out_byte", want.data, out_byte);
                    check_field("token_start", want.start, token_start);
                    check_field("empty_token", want.empty, empty_token);
                    check_field("param_index", want.pidx, param_index);
                    check_field("param_overflow", want.povf, param_overflow);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && !in_stall)
                predict_byte(data_byte);
            pending_count <= expected_records.size();
        end
    end

endmodule

// ===== tb/tb_irc_message_tokenizer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_irc_message_tokenizer_core: testbench of the IRC message tokenizer
// Feeds directed corner-case lines and then random messages, broken lines
// and noise through the byte channel under changing idle patterns on both
// sides, including one long receiver hold; the checker scores the records.
// ----------------------------------------------------------------------------
module tb_irc_message_tokenizer_core;
    import imt_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       token_start;
    logic       empty_token;
    logic [3:0] param_index;
    logic       param_overflow;
    logic       last;

    int fail_count;
    int pending_count;

    // Idle rates in percent and the long receiver hold.
    int   send_pct = 0;
    int   recv_pct = 0;
    logic stall_hold = 1'b0;

    // Bytes waiting to be sent.
    logic [7:0] byte_stream[$];

    irc_message_tokenizer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_byte       (out_byte),
        .token_start    (token_start),
        .empty_token    (empty_token),
        .param_index    (param_index),
        .param_overflow (param_overflow),
        .last           (last)
    );

    irc_message_tokenizer_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .out_byte       (out_byte),
        .token_start    (token_start),
        .empty_token    (empty_token),
        .param_index    (param_index),
        .param_overflow (param_overflow),
        .last           (last),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random stalls plus the long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= stall_hold || ($urandom_range(99) < recv_pct);
    end

    // Hard limit on the run time.
    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        if ($urandom_range(99) < 80)
            return 8'($urandom_range(8'h61, 8'h7A));
        do
            b = 8'($urandom_range(255));
        while (b == CH_CR || b == CH_SPACE || b == CH_COLON);
        return b;
    endfunction

    // Append one byte to the send queue.
    task automatic queue_byte(input logic [7:0] b);
        byte_stream = {byte_stream, b};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(8'(s[i]));
    endtask

    task automatic add_crlf();
        queue_byte(CH_CR);
        queue_byte(CH_LF);
    endtask

    // A token of plain bytes, now and then with a lone CR inside.
    task automatic add_token(input int unsigned len);
        repeat (len)
            queue_byte(($urandom_range(99) < 3) ? CH_CR : token_byte());
    endtask

    // One random line: mostly well-formed messages, some broken lines and noise.
    task automatic add_message();
        int unsigned shape;
        int unsigned nparam;
        logic [7:0]  b;
        shape = $urandom_range(99);
        if (shape < 8)
        begin
            repeat ($urandom_range(1, 8))
                queue_byte(8'($urandom_range(255)));
            return;
        end
        if (shape < 15)
        begin
            repeat ($urandom_range(1, 10))
            begin
                case ($urandom_range(4))
                    0: b = CH_CR;
                    1: b = CH_LF;
                    2: b = CH_SPACE;
                    3: b = CH_COLON;
                    default: b = 8'($urandom_range(255));
                endcase
                queue_byte(b);
            end
            add_crlf();
            return;
        end
        // Optional prefix, sometimes ending the line on its own.
        if ($urandom_range(99) < 30)
        begin
            queue_byte(CH_COLON);
            add_token($urandom_range(0, 5));
            if ($urandom_range(99) < 10)
            begin
                add_crlf();
                return;
            end
            queue_byte(CH_SPACE);
        end
        add_token($urandom_range(0, 6));
        // Parameters; a few lines run past the index range.
        nparam = ($urandom_range(99) < 12) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        repeat (nparam)
        begin
            queue_byte(CH_SPACE);
            add_token($urandom_range(0, 4));
        end
        if ($urandom_range(99) < 40)
        begin
            queue_byte(CH_SPACE);
            queue_byte(CH_COLON);
            repeat ($urandom_range(0, 10))
            begin
                do
                    b = 8'($urandom_range(255));
                while (b == CH_CR);
                queue_byte(b);
            end
        end
        else if ($urandom_range(99) < 10)
        begin
            queue_byte(CH_SPACE);
        end
        add_crlf();
    endtask

    // Offer one beat, idling first at the sender rate.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_stream();
        logic [7:0] b;
        while (byte_stream.size() > 0)
        begin
            b = byte_stream.pop_front();
            send_byte(b);
        end
    endtask

    task automatic run_phase(input int unsigned n_bytes);
        while (byte_stream.size() < n_bytes)
            add_message();
        send_stream();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: empty line, empty prefix, prefix with no space,
        // spaces only, empty trailing text, space at line end, lone CR.
        add_crlf();
        add_text(":");
        add_crlf();
        add_text(":p");
        add_crlf();
        add_text("  ");
        add_crlf();
        add_text("A :");
        add_crlf();
        add_text("B ");
        add_crlf();
        queue_byte(CH_CR);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        add_crlf();
        send_stream();

        // Sender idles often, receiver stalls often.
        send_pct <= 35;
        recv_pct <= 76;
        run_phase(500);

        send_pct <= 76;
        recv_pct <= 35;
        run_phase(500);

        // No idling; the receiver holds off long enough for the input to stall.
        send_pct <= 0;
        recv_pct <= 0;
        fork
            run_phase(500);
            begin
                stall_hold <= 1'b1;
                repeat (300) @(posedge clk);
                stall_hold <= 1'b0;
            end
        join

        // A few bytes after the last line end that never get closed.
        add_text("zz");
        send_stream();
        in_valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
